// File: hw/rtl/eds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the empirical distribution sampler.
// No dependencies.
package eds_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int VAL_W         = 16;
    localparam int WGT_W         = 32;
    localparam int ADD_W         = 24;
    localparam int TOT_W         = 40;
    localparam int DRAW_W        = 32;
    localparam int MASS_W        = 17;
    localparam int DIVD_W        = WGT_W + 16;
    localparam int ENT_W         = VAL_W + WGT_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_FALLBACK = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SCAN,
        S_SHIFT,
        S_INS,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic {
        REG_FLOOR   = 1'b0,
        REG_CEILING = 1'b1
    } t_reg;

    // Divider handshake
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [TOT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hw/rtl/eds_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module eds_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/eds_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle.
// Depends on eds_pkg.
module eds_div
    import eds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [TOT_W-1:0]  r_rem, n_rem;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [TOT_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [TOT_W:0]    sh;
    logic [TOT_W:0]    diff;

    always_comb begin
        sh     = {r_rem, r_quo[DIVD_W-1]};
        diff   = sh - {1'b0, r_dvs};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[TOT_W]) begin
                n_rem = diff[TOT_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                n_rem = sh[TOT_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DIVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: hw/rtl/empirical_distribution_sampler.sv
`timescale 1ns / 1ps
// Top level: inverse-CDF table sampler over a sorted value/weight table in RAM.
// Depends on eds_pkg, eds_ram and eds_div.
//
//  channel | direction | handshake                 | payload
//  in      | in        | i_in_valid / o_in_stall   | operation, entry_value/weight, draw
//  out     | out       | o_out_valid / i_out_stall | result_value, mass_fraction, status
//  cfg     | in        | APB psel/penable/pready   | floor_value, ceiling_value
//
// One item at a time. Clear and skipped adds go straight to the output state; a sample
// multiplies, then walks the entries; a query walks the entries, then runs the 48-step divider;
// an insert walks the entries, then moves those above the slot up, one entry moved a cycle.
// Reset (synchronous) empties the table; RAM contents need no clearing.
// A result waiting on i_out_stall holds the sequencer before its output load only.
module empirical_distribution_sampler
    import eds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [VAL_W-1:0]     i_entry_value,
    input  logic [ADD_W-1:0]     i_entry_weight,
    input  logic [DRAW_W-1:0]    i_uniform_draw,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [VAL_W-1:0]     o_result_value,
    output logic [MASS_W-1:0]    o_mass_fraction,
    output logic [1:0]           o_status,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_state r_state, n_state;

    logic [VAL_W-1:0]  r_floor, r_ceil;
    t_op               r_op;
    logic [VAL_W-1:0]  r_v;
    logic [ADD_W-1:0]  r_w;
    logic [DRAW_W-1:0] r_d;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TOT_W-1:0]  r_tot, n_tot;
    logic [CNT_W-1:0]  r_iss, n_iss;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_dv, n_dv;
    logic [IDX_W-1:0]  r_didx, n_didx;
    logic [TOT_W:0]    r_cum, n_cum;
    logic [TOT_W:0]    r_phi, n_phi;
    logic              r_plo0, n_plo0;
    logic [63:0]       r_prod;
    logic [VAL_W-1:0]  r_last, n_last;
    logic [VAL_W-1:0]  r_res_v, n_res_v;
    logic [MASS_W-1:0] r_res_m, n_res_m;
    t_status           r_res_s, n_res_s;
    logic              r_ovalid;
    logic [VAL_W-1:0]  r_oval;
    logic [MASS_W-1:0] r_omass;
    logic [1:0]        r_ostat;

    logic              in_acc, out_acc, slot_free, cfg_wr;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;
    logic [VAL_W-1:0]  rd_val;
    logic [WGT_W-1:0]  rd_w;
    logic [TOT_W:0]    cum_next;
    logic              scan_hit, scan_end;
    logic [VAL_W-1:0]  ceil_eff;
    logic [VAL_W:0]    span;
    logic [31:0]       mul_b;
    logic [DRAW_W+TOT_W-33:0] hi_prod;
    logic [WGT_W:0]    msum;
    logic [WGT_W-1:0]  msat;
    logic [TOT_W:0]    tsum;
    logic [TOT_W-1:0]  tadd;
    logic [VAL_W-1:0]  samp;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = r_ovalid && !i_out_stall;
    assign slot_free = !r_ovalid || !i_out_stall;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[2]))
            REG_FLOOR:   prdata = {16'd0, r_floor};
            REG_CEILING: prdata = {16'd0, r_ceil};
            default:     prdata = '0;
        endcase
    end

    eds_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENT_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    eds_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign rd_val   = ram_rdata[ENT_W-1:WGT_W];
    assign rd_w     = ram_rdata[WGT_W-1:0];
    assign cum_next = r_cum + (TOT_W+1)'(rd_w);
    assign scan_end = (r_iss >= r_cnt) && !r_dv;
    assign scan_hit = r_dv && ((r_op == OP_SAMPLE)
                      ? ((cum_next > r_phi) || ((cum_next == r_phi) && r_plo0))
                      : (rd_val >= r_v));
    assign ceil_eff = (r_ceil < r_floor) ? r_floor : r_ceil;
    assign span     = {1'b0, ceil_eff} - {1'b0, r_floor} + 1'b1;
    assign mul_b    = (r_cnt == '0) ? 32'(span) : r_tot[31:0];
    assign hi_prod  = r_d * r_tot[TOT_W-1:32];
    assign msum     = {1'b0, rd_w} + (WGT_W+1)'(r_w);
    assign msat     = msum[WGT_W] ? '1 : msum[WGT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_CLEAR:  n_state = S_OUT;
                        OP_ADD:    n_state = ((i_entry_value < r_floor) || (i_entry_weight == '0))
                                             ? S_OUT : S_SCAN;
                        OP_SAMPLE: n_state = S_MUL1;
                        OP_QUERY:  n_state = S_SCAN;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = (r_cnt == '0) ? S_OUT : S_SCAN;
            S_SCAN: begin
                if (scan_hit || scan_end) begin
                    case (r_op)
                        OP_ADD: begin
                            if (scan_hit && (rd_val == r_v)) begin
                                n_state = S_OUT;
                            end else if (r_cnt == CNT_W'(TABLE_ENTRIES)) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        OP_QUERY: n_state = (scan_hit && (rd_val == r_v) && (r_tot != '0))
                                            ? S_DIV : S_OUT;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_SHIFT: if ((r_iss <= r_pos) && !r_dv) n_state = S_INS;
            S_INS:   n_state = S_OUT;
            S_DIV:   if (div_rsp.done) n_state = S_OUT;
            S_OUT:   if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_cnt   = r_cnt;
        n_tot   = r_tot;
        n_iss   = r_iss;
        n_pos   = r_pos;
        n_dv    = 1'b0;
        n_didx  = r_didx;
        n_cum   = r_cum;
        n_phi   = r_phi;
        n_plo0  = r_plo0;
        n_last  = r_last;
        n_res_v = r_res_v;
        n_res_m = r_res_m;
        n_res_s = r_res_s;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        div_req   = '0;
        tsum      = '0;
        tadd      = '0;
        samp      = '0;
        unique case (r_state)
            S_IDLE: begin
                n_iss   = '0;
                n_cum   = '0;
                n_res_v = '0;
                n_res_m = '0;
                n_res_s = ST_OK;
                if (in_acc) begin
                    if (t_op'(i_operation) == OP_CLEAR) begin
                        n_cnt = '0;
                        n_tot = '0;
                    end else if ((t_op'(i_operation) == OP_ADD) &&
                                 ((i_entry_value < r_floor) || (i_entry_weight == '0))) begin
                        n_res_s = ST_SKIPPED;
                    end
                end
            end
            S_MUL1: ;
            S_MUL2: begin
                n_phi  = (TOT_W+1)'(r_prod[63:32]) + (TOT_W+1)'(hi_prod);
                n_plo0 = (r_prod[31:0] == '0);
                n_res_s = (r_cnt == '0) ? ST_FALLBACK : ST_OK;
                n_res_v = r_floor + r_prod[32 +: VAL_W];
            end
            S_SCAN: begin
                // Stream entries upward, one read issued a cycle
                if (r_iss < r_cnt) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_iss[IDX_W-1:0];
                    n_dv      = 1'b1;
                    n_didx    = r_iss[IDX_W-1:0];
                    n_iss     = r_iss + 1'b1;
                end
                if (r_dv) begin
                    n_cum  = cum_next;
                    n_last = rd_val;
                end
                if (scan_hit || scan_end) begin
                    n_dv = 1'b0;
                    case (r_op)
                        OP_SAMPLE: begin
                            samp    = scan_hit ? rd_val : r_last;
                            n_res_v = (samp < r_floor) ? r_floor : samp;
                        end
                        OP_ADD: begin
                            if (scan_hit && (rd_val == r_v)) begin
                                // Merge into the equal entry, saturating
                                ram_we    = 1'b1;
                                ram_waddr = r_didx;
                                ram_wdata = {r_v, msat};
                                tadd      = TOT_W'(msat - rd_w);
                                tsum      = {1'b0, r_tot} + {1'b0, tadd};
                                n_tot     = tsum[TOT_W] ? '1 : tsum[TOT_W-1:0];
                            end else if (r_cnt == CNT_W'(TABLE_ENTRIES)) begin
                                n_res_s = ST_FULL;
                            end else begin
                                n_pos = scan_hit ? CNT_W'(r_didx) : r_cnt;
                                n_iss = r_cnt;
                            end
                        end
                        OP_QUERY: begin
                            if (scan_hit && (rd_val == r_v) && (r_tot != '0)) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {rd_w, 16'd0};
                                div_req.divisor  = r_tot;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                // Move entries up by one, from the top down to the slot
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_didx + 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (r_iss > r_pos) begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(r_iss - 1'b1);
                    n_dv      = 1'b1;
                    n_didx    = IDX_W'(r_iss - 1'b1);
                    n_iss     = r_iss - 1'b1;
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[IDX_W-1:0];
                ram_wdata = {r_v, WGT_W'(r_w)};
                n_cnt     = r_cnt + 1'b1;
                tadd      = TOT_W'(r_w);
                tsum      = {1'b0, r_tot} + {1'b0, tadd};
                n_tot     = tsum[TOT_W] ? '1 : tsum[TOT_W-1:0];
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res_m = (div_rsp.quotient > DIVD_W'(65536)) ? MASS_W'(65536)
                              : div_rsp.quotient[MASS_W-1:0];
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_tot    <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_floor  <= '0;
            r_ceil   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_tot   <= n_tot;
            r_dv    <= n_dv;
            if (r_state == S_OUT && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                case (t_reg'(paddr[2]))
                    REG_FLOOR:   r_floor <= pwdata[VAL_W-1:0];
                    REG_CEILING: r_ceil  <= pwdata[VAL_W-1:0];
                    default: ;
                endcase
            end
        end
        if (in_acc) begin
            r_op <= t_op'(i_operation);
            r_v  <= i_entry_value;
            r_w  <= i_entry_weight;
            r_d  <= i_uniform_draw;
        end
        if (r_state == S_MUL1) begin
            r_prod <= r_d * mul_b;
        end
        r_iss   <= n_iss;
        r_pos   <= n_pos;
        r_didx  <= n_didx;
        r_cum   <= n_cum;
        r_phi   <= n_phi;
        r_plo0  <= n_plo0;
        r_last  <= n_last;
        r_res_v <= n_res_v;
        r_res_m <= n_res_m;
        r_res_s <= n_res_s;
        if (r_state == S_OUT && slot_free) begin
            r_oval  <= r_res_v;
            r_omass <= r_res_m;
            r_ostat <= r_res_s;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_result_value  = r_oval;
    assign o_mass_fraction = r_omass;
    assign o_status        = r_ostat;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table write while idle");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_CLEAR)) |=> ((r_cnt == '0) && (r_tot == '0)))
        else $error("clear left entries");

    a_out_after_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && slot_free) |=> o_out_valid)
        else $error("result not presented");

endmodule
